// ----- design/dcto_pkg.sv -----
// Shared types and constants for the digital I/O change-event and timed-output core.
// Used by the front, back, top level and checker; depends on nothing else.

package dcto_pkg;

  localparam int FIFO_DEPTH    = 128;
  localparam int PATTERN_DEPTH = 256;
  localparam int PIN_COUNT     = 8;
  localparam int CMDQ_DEPTH    = 2;

  localparam int FIFO_AW  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW  = $clog2(FIFO_DEPTH + 1);
  localparam int PAT_AW   = $clog2(PATTERN_DEPTH);
  localparam int PAT_CW   = $clog2(PATTERN_DEPTH + 1);
  localparam int BIT_W    = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  localparam int CMDQ_AW  = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CW  = $clog2(CMDQ_DEPTH + 1);

  localparam logic [15:0] RESET_OUTPUT_PERIOD = 16'd500;
  localparam logic [7:0]  RESET_SCAN_PERIOD   = 8'd200;
  localparam logic [7:0]  EVENT_BASE          = 8'h30;
  localparam logic [7:0]  EVENT_RISING        = 8'h80;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_POP    = 2'd1,
    OP_LOAD   = 2'd2,
    OP_DIRECT = 2'd3
  } dcto_op_t;

  typedef enum logic [1:0] {
    CFG_OUTPUT_MODE   = 2'd0,
    CFG_OUTPUT_PERIOD = 2'd1,
    CFG_SCAN_PERIOD   = 2'd2
  } dcto_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECTED = 2'd1,
    ST_IGNORED  = 2'd2
  } dcto_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_PLAYWAIT,
    BK_SCAN,
    BK_POPWAIT,
    BK_RESP
  } dcto_state_t;

  typedef struct packed {
    dcto_op_t   kind;
    logic [7:0] pins;
    logic [7:0] data;
    logic       last;
  } dcto_cmd_t;

  typedef struct packed {
    logic [7:0]   pins_out;
    logic         pins_updated;
    logic [7:0]   event_code;
    logic         event_valid;
    logic [7:0]   queue_level;
    logic         playback_busy;
    dcto_status_t status;
  } dcto_result_t;

endpackage

// ----- design/dcto_front.sv -----
// Front end: accepts command beats, classifies them and holds them in a short queue.
// Depends on dcto_pkg.

module dcto_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          in_op,
  input  logic [7:0]          in_pins_in,
  input  logic [7:0]          in_data_byte,
  input  logic                in_load_last,
  output logic                busy,
  output logic                cmd_valid,
  output dcto_pkg::dcto_cmd_t cmd,
  input  logic                cmd_pop,
  output logic                queue_empty
);
  import dcto_pkg::*;

  dcto_cmd_t            q_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wptr_r, wptr_nxt;
  logic [CMDQ_AW-1:0]   rptr_r, rptr_nxt;
  logic [CMDQ_CW-1:0]   cnt_r, cnt_nxt;
  dcto_cmd_t            entry;
  logic                 push;
  logic                 pop;

  // Fields that the command kind does not use are zeroed so the back end sees clean beats.
  always_comb begin
    entry = '0;
    entry.data = in_data_byte;
    case (in_op)
      OP_TICK: begin
        entry.kind = OP_TICK;
        entry.pins = in_pins_in;
        entry.data = '0;
      end
      OP_POP: begin
        entry.kind = OP_POP;
        entry.data = '0;
      end
      OP_LOAD: begin
        entry.kind = OP_LOAD;
        entry.last = in_load_last;
      end
      default: begin
        entry.kind = OP_DIRECT;
      end
    endcase
  end

  assign busy        = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign queue_empty = (cnt_r == '0);
  assign cmd_valid   = !queue_empty;
  assign cmd         = q_r[rptr_r];
  assign push        = start && !busy;
  assign pop         = cmd_pop && cmd_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= entry;
    end
  end

endmodule

// ----- design/dcto_back.sv -----
// Back end: sequencer that executes queued commands against the event FIFO, the pattern
// store and the output latch, and holds the configuration registers. Depends on dcto_pkg.

module dcto_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  input  dcto_pkg::dcto_cmd_t    cmd,
  output logic                   cmd_pop,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  output logic                   back_idle,
  output logic                   res_strobe,
  output dcto_pkg::dcto_result_t res
);
  import dcto_pkg::*;

  dcto_state_t            state_r, state_nxt;

  logic                   mode_r, mode_nxt;
  logic [15:0]            period_r, period_nxt;
  logic [7:0]             scan_per_r, scan_per_nxt;

  logic [PIN_COUNT-1:0]   prev_r, prev_nxt;
  logic [7:0]             scan_cnt_r, scan_cnt_nxt;
  logic [FIFO_AW-1:0]     head_r, head_nxt;
  logic [FIFO_AW-1:0]     tail_r, tail_nxt;
  logic [FIFO_CW-1:0]     count_r, count_nxt;
  logic [PAT_CW-1:0]      plen_r, plen_nxt;
  logic [PAT_CW-1:0]      ppos_r, ppos_nxt;
  logic [PAT_CW-1:0]      lpos_r, lpos_nxt;
  logic [15:0]            pcnt_r, pcnt_nxt;
  logic                   playing_r, playing_nxt;
  logic [PIN_COUNT-1:0]   latch_r, latch_nxt;

  dcto_cmd_t              cmd_r, cmd_nxt;
  logic                   updated_r, updated_nxt;
  logic [7:0]             code_r, code_nxt;
  logic                   valid_r, valid_nxt;
  dcto_status_t           status_r, status_nxt;
  logic [PIN_COUNT-1:0]   diff_r, diff_nxt;
  logic [BIT_W-1:0]       bit_r, bit_nxt;
  logic                   scan_go_r, scan_go_nxt;
  logic                   play_rd_r, play_rd_nxt;

  logic                   strobe_r, strobe_nxt;
  dcto_result_t           res_r, res_nxt;

  logic [7:0]             fifo_mem [FIFO_DEPTH];
  logic                   fifo_we, fifo_re;
  logic [FIFO_AW-1:0]     fifo_waddr, fifo_raddr;
  logic [7:0]             fifo_wdata, fifo_rdata_r;

  logic [7:0]             pat_mem [PATTERN_DEPTH];
  logic                   pat_we, pat_re;
  logic [PAT_AW-1:0]      pat_waddr, pat_raddr;
  logic [7:0]             pat_rdata_r;

  logic [15:0]            pcnt_inc;
  logic [7:0]             scan_inc;
  logic [PAT_CW-1:0]      ppos_inc;
  logic                   play_due;
  logic                   fire;
  logic                   scan_hit;
  logic                   take_cmd;

  assign pcnt_inc = pcnt_r + 16'd1;
  assign scan_inc = scan_cnt_r + 8'd1;
  assign ppos_inc = ppos_r + 1'b1;
  assign play_due = playing_r && (pcnt_inc >= period_r);
  assign fire     = play_due && (plen_r != '0);
  assign scan_hit = (scan_inc >= scan_per_r);
  assign take_cmd = cmd_valid && ((state_r == BK_IDLE) || (state_r == BK_RESP));

  assign cmd_pop    = take_cmd;
  assign back_idle  = (state_r == BK_IDLE);
  assign res_strobe = strobe_r;
  assign res        = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) state_nxt = BK_EXEC;
      end
      BK_EXEC: begin
        case (cmd_r.kind)
          OP_TICK: begin
            if (fire) begin
              state_nxt = BK_PLAYWAIT;
            end else if (scan_hit) begin
              state_nxt = BK_SCAN;
            end else begin
              state_nxt = BK_RESP;
            end
          end
          OP_POP: begin
            state_nxt = (count_r != '0) ? BK_POPWAIT : BK_RESP;
          end
          default: begin
            state_nxt = BK_RESP;
          end
        endcase
      end
      BK_PLAYWAIT: begin
        state_nxt = scan_go_r ? BK_SCAN : BK_RESP;
      end
      BK_SCAN: begin
        if (bit_r == BIT_W'(PIN_COUNT - 1)) state_nxt = BK_RESP;
      end
      BK_POPWAIT: begin
        state_nxt = BK_RESP;
      end
      BK_RESP: begin
        state_nxt = cmd_valid ? BK_EXEC : BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    mode_nxt     = mode_r;
    period_nxt   = period_r;
    scan_per_nxt = scan_per_r;
    prev_nxt     = prev_r;
    scan_cnt_nxt = scan_cnt_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    plen_nxt     = plen_r;
    ppos_nxt     = ppos_r;
    lpos_nxt     = lpos_r;
    pcnt_nxt     = pcnt_r;
    playing_nxt  = playing_r;
    latch_nxt    = latch_r;
    cmd_nxt      = cmd_r;
    updated_nxt  = updated_r;
    code_nxt     = code_r;
    valid_nxt    = valid_r;
    status_nxt   = status_r;
    diff_nxt     = diff_r;
    bit_nxt      = bit_r;
    scan_go_nxt  = scan_go_r;
    play_rd_nxt  = play_rd_r;
    strobe_nxt   = 1'b0;
    res_nxt      = res_r;
    fifo_we      = 1'b0;
    fifo_re      = 1'b0;
    fifo_waddr   = head_r;
    fifo_raddr   = tail_r;
    fifo_wdata   = EVENT_BASE + 8'(bit_r);
    pat_we       = 1'b0;
    pat_re       = 1'b0;
    pat_waddr    = lpos_r[PAT_AW-1:0];
    pat_raddr    = ppos_r[PAT_AW-1:0];

    case (state_r)
      BK_EXEC: begin
        case (cmd_r.kind)
          OP_TICK: begin
            // Playback steps first; the input scan follows in later cycles.
            if (playing_r) begin
              pcnt_nxt = play_due ? '0 : pcnt_inc;
            end
            play_rd_nxt = 1'b0;
            if (fire) begin
              pat_re      = (ppos_r < PAT_CW'(PATTERN_DEPTH));
              play_rd_nxt = pat_re;
              updated_nxt = 1'b1;
              ppos_nxt    = ppos_inc;
              if (ppos_inc >= plen_r) playing_nxt = 1'b0;
            end
            scan_cnt_nxt = scan_hit ? '0 : scan_inc;
            scan_go_nxt  = scan_hit;
            bit_nxt      = '0;
            if (scan_hit) begin
              diff_nxt = prev_r ^ cmd_r.pins[PIN_COUNT-1:0];
              prev_nxt = cmd_r.pins[PIN_COUNT-1:0];
            end
          end
          OP_POP: begin
            if (count_r != '0) begin
              fifo_re   = 1'b1;
              tail_nxt  = (tail_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;
              count_nxt = count_r - 1'b1;
              valid_nxt = 1'b1;
            end
          end
          OP_LOAD: begin
            if (!mode_r) begin
              status_nxt = ST_IGNORED;
            end else if (playing_r) begin
              status_nxt = ST_REJECTED;
            end else begin
              if (lpos_r < PAT_CW'(PATTERN_DEPTH)) begin
                pat_we   = 1'b1;
                lpos_nxt = lpos_r + 1'b1;
              end
              if (cmd_r.last) begin
                plen_nxt    = pat_we ? lpos_r + 1'b1 : lpos_r;
                ppos_nxt    = '0;
                lpos_nxt    = '0;
                playing_nxt = 1'b1;
              end
            end
          end
          default: begin
            if (mode_r) begin
              status_nxt = ST_IGNORED;
            end else begin
              latch_nxt   = cmd_r.data[PIN_COUNT-1:0];
              updated_nxt = 1'b1;
            end
          end
        endcase
      end
      BK_PLAYWAIT: begin
        if (play_rd_r) latch_nxt = pat_rdata_r[PIN_COUNT-1:0];
      end
      BK_SCAN: begin
        // One changed bit per cycle goes into the FIFO; a full FIFO drops it.
        if (diff_r[bit_r] && (count_r < FIFO_CW'(FIFO_DEPTH))) begin
          fifo_we   = 1'b1;
          head_nxt  = (head_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_nxt = count_r + 1'b1;
          if (cmd_r.pins[bit_r]) fifo_wdata = EVENT_BASE + 8'(bit_r) | EVENT_RISING;
        end
        bit_nxt = bit_r + 1'b1;
      end
      BK_POPWAIT: begin
        code_nxt = fifo_rdata_r;
      end
      BK_RESP: begin
        strobe_nxt            = 1'b1;
        res_nxt.pins_out      = 8'(latch_r);
        res_nxt.pins_updated  = updated_r;
        res_nxt.event_code    = code_r;
        res_nxt.event_valid   = valid_r;
        res_nxt.queue_level   = 8'(count_r);
        res_nxt.playback_busy = playing_r;
        res_nxt.status        = status_r;
      end
      default: begin
      end
    endcase

    if (take_cmd) begin
      cmd_nxt     = cmd;
      updated_nxt = 1'b0;
      code_nxt    = '0;
      valid_nxt   = 1'b0;
      status_nxt  = ST_OK;
    end

    // Register writes arrive only while the sequencer is idle.
    if (cfg_we) begin
      case (cfg_index)
        CFG_OUTPUT_MODE: begin
          mode_nxt    = cfg_data[0];
          playing_nxt = 1'b0;
          if (cfg_data[0]) begin
            plen_nxt = '0;
            ppos_nxt = '0;
            lpos_nxt = '0;
          end
        end
        CFG_OUTPUT_PERIOD: period_nxt   = cfg_data;
        CFG_SCAN_PERIOD:   scan_per_nxt = cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      mode_r     <= 1'b0;
      period_r   <= RESET_OUTPUT_PERIOD;
      scan_per_r <= RESET_SCAN_PERIOD;
      prev_r     <= '0;
      scan_cnt_r <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      plen_r     <= '0;
      ppos_r     <= '0;
      lpos_r     <= '0;
      pcnt_r     <= '0;
      playing_r  <= 1'b0;
      latch_r    <= '0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      period_r   <= period_nxt;
      scan_per_r <= scan_per_nxt;
      prev_r     <= prev_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      plen_r     <= plen_nxt;
      ppos_r     <= ppos_nxt;
      lpos_r     <= lpos_nxt;
      pcnt_r     <= pcnt_nxt;
      playing_r  <= playing_nxt;
      latch_r    <= latch_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    updated_r <= updated_nxt;
    code_r    <= code_nxt;
    valid_r   <= valid_nxt;
    status_r  <= status_nxt;
    diff_r    <= diff_nxt;
    bit_r     <= bit_nxt;
    scan_go_r <= scan_go_nxt;
    play_rd_r <= play_rd_nxt;
    res_r     <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (fifo_we) fifo_mem[fifo_waddr] <= fifo_wdata;
    if (fifo_re) fifo_rdata_r <= fifo_mem[fifo_raddr];
  end

  always_ff @(posedge clk) begin
    if (pat_we) pat_mem[pat_waddr] <= cmd_r.data;
    if (pat_re) pat_rdata_r <= pat_mem[pat_raddr];
  end

endmodule

// ----- design/dio_change_events_and_timed_output_core.sv -----
// Top level of the digital I/O change-event and timed-output core.
// Instantiates dcto_front and dcto_back; depends on dcto_pkg.

// An item is taken on a clock edge with start high and busy low; its result appears on the
// out_ ports for exactly one cycle, marked by out_strobe, and cannot be held off, so the
// receiver must take every strobed beat. The front holds up to two commands, so busy rises
// only when two are waiting behind the one in progress. The back sequencer sets the rate:
// a load, direct write or empty pop runs an execute and a response state, a pop with an
// event adds a FIFO read-wait state, and a tick adds a pattern-read state when a pattern
// byte is driven and a scan state per pin when an input scan runs (one event per cycle
// into the event FIFO's write port). With the back idle, an accepted item leaves the
// queue, runs its states, and out_strobe is registered from the response state; the
// result beat is taken at the edge that ends the strobe. Register writes are taken only
// while no item is queued or in progress (cfg_ready high); no clearing pass after reset.

module dio_change_events_and_timed_output_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_pins_in,
  input  logic [7:0]  in_data_byte,
  input  logic        in_load_last,
  output logic        out_strobe,
  output logic [7:0]  out_pins_out,
  output logic        out_pins_updated,
  output logic [7:0]  out_event_code,
  output logic        out_event_valid,
  output logic [7:0]  out_queue_level,
  output logic        out_playback_busy,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dcto_pkg::*;

  logic         cmd_valid;
  dcto_cmd_t    cmd;
  logic         cmd_pop;
  logic         queue_empty;
  logic         back_idle;
  logic         res_strobe;
  dcto_result_t res;

  dcto_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_op        (in_op),
    .in_pins_in   (in_pins_in),
    .in_data_byte (in_data_byte),
    .in_load_last (in_load_last),
    .busy         (busy),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .queue_empty  (queue_empty)
  );

  dcto_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .back_idle  (back_idle),
    .res_strobe (res_strobe),
    .res        (res)
  );

  assign cfg_ready         = queue_empty && back_idle;
  assign out_strobe        = res_strobe;
  assign out_pins_out      = res.pins_out;
  assign out_pins_updated  = res.pins_updated;
  assign out_event_code    = res.event_code;
  assign out_event_valid   = res.event_valid;
  assign out_queue_level   = res.queue_level;
  assign out_playback_busy = res.playback_busy;
  assign out_status        = res.status;

endmodule

// ----- design/dcto_checker.sv -----
// Port-level checker for the digital I/O change-event and timed-output core, with its bind.
// Depends on dcto_pkg and the top-level port list.

module dcto_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_strobe,
  input logic       out_pins_updated,
  input logic [7:0] out_event_code,
  input logic       out_event_valid,
  input logic [7:0] out_queue_level,
  input logic [1:0] out_status
);
  import dcto_pkg::*;

  // The sequencer passes through its execute state between result beats.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result beats on adjacent cycles");

  a_event_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_event_valid) |-> (out_event_code[6:4] == 3'b011))
    else $error("popped event code is malformed");

  a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_event_valid) |-> (out_event_code == 8'd0))
    else $error("event code set without a popped event");

  a_refused_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != ST_OK)) |-> !out_pins_updated)
    else $error("refused item updated the output pins");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_queue_level <= 8'(FIFO_DEPTH)))
    else $error("queue level beyond FIFO depth");

endmodule

bind dio_change_events_and_timed_output_core dcto_checker u_dcto_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_strobe       (out_strobe),
  .out_pins_updated (out_pins_updated),
  .out_event_code   (out_event_code),
  .out_event_valid  (out_event_valid),
  .out_queue_level  (out_queue_level),
  .out_status       (out_status)
);
